/* rtl/mbps_pkg.sv */
// Shared constants, register map and configuration bundle for the masked byte scanner.
package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF       = 32;

  localparam int unsigned CFG_ADDR_W   = 6;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned LEN_REG_W    = 5;
  localparam int unsigned OUT_OFFSET_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK_LOW       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK_HIGH      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  typedef struct packed {
    logic [63:0]          pattern_low;
    logic [63:0]          pattern_high;
    logic [63:0]          mask_low;
    logic [63:0]          mask_high;
    logic [LEN_REG_W-1:0] pattern_length;
  } cfg_t;

endpackage

/* rtl/mbps_cfg.sv */
// Configuration register bank with its APB-style access port.
module mbps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output mbps_pkg::cfg_t                    cfg
);

  mbps_pkg::cfg_t                     cfg_r;
  logic [mbps_pkg::REG_IDX_W-1:0]     idx;
  logic                               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[mbps_pkg::CFG_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.mask_low       <= '1;
      cfg_r.mask_high      <= '1;
      cfg_r.pattern_length <= mbps_pkg::LEN_REG_W'(1);
    end else if (wr_en) begin
      case (idx)
        mbps_pkg::REG_PATTERN_LOW:    cfg_r.pattern_low  <= pwdata;
        mbps_pkg::REG_PATTERN_HIGH:   cfg_r.pattern_high <= pwdata;
        mbps_pkg::REG_MASK_LOW:       cfg_r.mask_low     <= pwdata;
        mbps_pkg::REG_MASK_HIGH:      cfg_r.mask_high    <= pwdata;
        mbps_pkg::REG_PATTERN_LENGTH:
          cfg_r.pattern_length <= pwdata[mbps_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mbps_pkg::REG_PATTERN_LOW:    prdata = cfg_r.pattern_low;
      mbps_pkg::REG_PATTERN_HIGH:   prdata = cfg_r.pattern_high;
      mbps_pkg::REG_MASK_LOW:       prdata = cfg_r.mask_low;
      mbps_pkg::REG_MASK_HIGH:      prdata = cfg_r.mask_high;
      mbps_pkg::REG_PATTERN_LENGTH:
        prdata = mbps_pkg::CFG_DATA_W'(cfg_r.pattern_length);
      default:                      prdata = '0;
    endcase
  end

endmodule

/* rtl/mbps_cmp.sv */
// Parallel masked compare of the window against the configured pattern.
module mbps_cmp #(
  parameter int unsigned MAX_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_BYTES)
) (
  input  logic [MAX_BYTES-1:0][7:0] win,     // newest byte at index 0
  input  mbps_pkg::cfg_t            cfg,
  input  logic [IDX_W-1:0]          len_m1,  // pattern length minus one
  output logic                      hit
);

  always_comb begin
    logic [IDX_W-1:0] idx;
    logic [7:0]       m;
    logic [7:0]       p;
    hit = 1'b1;
    for (int k = 0; k < MAX_BYTES; k++) begin
      idx = len_m1 - IDX_W'(k);
      if (k < 8) begin
        m = cfg.mask_low[8*(k%8) +: 8];
        p = cfg.pattern_low[8*(k%8) +: 8];
      end else begin
        m = cfg.mask_high[8*(k%8) +: 8];
        p = cfg.pattern_high[8*(k%8) +: 8];
      end
      // pattern byte k lines up with the byte len-1-k positions back
      if ((k <= int'(len_m1)) && ((win[idx] & m) != p)) begin
        hit = 1'b0;
      end
    end
  end

endmodule

/* rtl/masked_byte_pattern_scan.sv */
// Masked byte pattern scanner: top level with stream ports and config port.
// The block takes one region byte per cycle on the in_ stream (tlast marks the
// region's last byte) and keeps a sliding window of the last MAX_PATTERN_BYTES
// bytes. Each word passes an input register, then parallel masked compares
// against the configured pattern, and lands in the output register; a new byte
// is taken in every cycle while the output side keeps up. At most one result
// per region leaves on the out_ stream: the first match offset with found set,
// or, when the region ends without a match, found clear and offset zero on its
// last byte. The region byte counter saturates; offsets are reported modulo
// 2^32. Pattern, mask and length are written through the cfg_ port (64-bit
// registers at byte addresses 0, 8, 16, 24 and 32); the user must write them
// only while the stream is idle, and the block itself does not enforce this.
module masked_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // [7:0] data_byte
  input  logic                                  in_tlast,   // region_end
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [mbps_pkg::OUT_OFFSET_W-1:0]     out_tdata,  // [31:0] match_offset
  output logic                                  out_tuser,  // [0] found
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned IDX_W = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned EXT_W =
    (OFFSET_BITS > mbps_pkg::OUT_OFFSET_W) ? OFFSET_BITS : mbps_pkg::OUT_OFFSET_W;

  mbps_pkg::cfg_t cfg;

  logic                                s1_valid_r;
  logic [7:0]                          s1_byte_r;
  logic                                s1_last_r;

  logic [MAX_PATTERN_BYTES-1:0][7:0]   win_r, win_nxt, win_shift;
  logic [OFFSET_BITS-1:0]              count_r, count_nxt;
  logic                                seen_r, seen_nxt;

  logic                                out_valid_r;
  logic                                out_found_r;
  logic [mbps_pkg::OUT_OFFSET_W-1:0]   out_offset_r;

  logic                                adv, fire;
  logic [IDX_W-1:0]                    len_m1;
  logic                                cmp_hit, hit_now, res_valid;
  logic [OFFSET_BITS-1:0]              offset_full;
  logic [EXT_W-1:0]                    offset_ext;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // length 0 acts as 1, above the window size acts as the window size
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_m1 = '0;
    end else if (int'(cfg.pattern_length) > MAX_PATTERN_BYTES) begin
      len_m1 = IDX_W'(MAX_PATTERN_BYTES - 1);
    end else begin
      len_m1 = IDX_W'(cfg.pattern_length - mbps_pkg::LEN_REG_W'(1));
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_comb begin
    win_shift[0] = s1_byte_r;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_shift[j] = win_r[j-1];
    end
  end

  mbps_cmp #(
    .MAX_BYTES (MAX_PATTERN_BYTES)
  ) u_cmp (
    .win    (win_shift),
    .cfg    (cfg),
    .len_m1 (len_m1),
    .hit    (cmp_hit)
  );

  assign hit_now     = !seen_r && (count_r >= OFFSET_BITS'(len_m1)) && cmp_hit;
  assign res_valid   = hit_now || (s1_last_r && !seen_r);
  assign offset_full = count_r - OFFSET_BITS'(len_m1);
  assign offset_ext  = EXT_W'(offset_full);

  // region end clears the window, the count and the match flag
  always_comb begin
    if (s1_last_r) begin
      win_nxt   = '0;
      count_nxt = '0;
      seen_nxt  = 1'b0;
    end else begin
      win_nxt   = win_shift;
      count_nxt = (count_r == '1) ? count_r : count_r + OFFSET_BITS'(1);
      seen_nxt  = seen_r || hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
      count_r    <= '0;
      seen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        win_r   <= win_nxt;
        count_r <= count_nxt;
        seen_r  <= seen_nxt;
      end
      if (fire) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (fire && res_valid) begin
      out_found_r  <= hit_now;
      out_offset_r <= hit_now ? offset_ext[mbps_pkg::OUT_OFFSET_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_offset_r;

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_last_r |=> (count_r == '0) && !seen_r)
    else $error("region state not cleared after last word");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_offset_r == '0)
    else $error("not-found result with nonzero offset");

  a_seen_counted: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> count_r != '0)
    else $error("match flag set with empty region count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !fire |=> $stable(out_offset_r) && $stable(out_found_r))
    else $error("result register changed without a processed word");

endmodule
